>>> hdl/ice_pkg.sv
`default_nettype none
package ice_pkg;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_e;

  // one entry of the front-to-back queue
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } cmd_t;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    init_hash = h[i];
  endfunction

endpackage
`default_nettype wire

>>> hdl/ice_if.sv
`default_nettype none
interface ice_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface ice_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  word_index;
  logic [63:0] digest_word;
  logic [15:0] sum_result;
  logic [15:0] crc_result;
  logic        last;
  modport source (output valid, word_index, digest_word, sum_result, crc_result, last,
                  input ready);
  modport sink   (input valid, word_index, digest_word, sum_result, crc_result, last,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/image_checksum_engine.sv
`default_nettype none
// Byte-stream checksum engine: each data item absorbs one byte into a 16-bit
// sum, CRC-16/CCITT-FALSE and SHA-256; a finish item pads the message and
// yields four result items (64 digest bits each, plus sum and CRC, last on
// the fourth). Bytes are taken one per cycle into a two-entry queue and a
// 64-byte shift register. The 64th byte of a block starts a compression in
// the single shared round unit: the rounds, then an add into the chaining
// value; meanwhile intake stops once the queue is full. A finish item
// moves to padding, which shifts in one pad byte per cycle until the block
// is full (64 minus the bytes held) and then compresses it; when 56 or more
// bytes were held a second block of zeros and length follows (another 64
// pad bytes and a compression). The four result items then follow, each
// held until the receiver takes it.
module image_checksum_engine
  import ice_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ice_in_if.sink    in_i,
  ice_out_if.source out_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  ice_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  ice_back u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .out_o
  );

endmodule
`default_nettype wire

>>> hdl/ice_front.sv
`default_nettype none
module ice_front
  import ice_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ice_in_if.sink    in_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  wire logic cmd_ready_i
);

  // two-entry queue decouples intake from the hash engine
  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{fin: (in_i.kind == KIND_FINISH), data: in_i.data_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> hdl/ice_back.sv
`default_nettype none
module ice_back
  import ice_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  ice_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT
  } state_e;

  state_e       state_q;
  logic [511:0] msg_q;     // byte shift register, oldest byte at the top
  logic [5:0]   fill_q;
  logic [63:0]  bitlen_q;
  logic [15:0]  sum_q, crc_q;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   rnd_q;
  logic         final_q;   // compression belongs to a finish
  logic         second_q;  // length block still to follow
  logic         pad80_q;   // next pad byte is the 0x80 marker
  logic         ovf_q;     // current pad block carries no length
  logic [1:0]   idx_q;
  logic         ovalid_q;

  // crc of one byte, eight shift steps
  logic [15:0] crc_next;
  always_comb begin
    crc_next = crc_q ^ {cmd_i.data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      crc_next = crc_next[15] ? ((crc_next << 1) ^ CrcPoly) : (crc_next << 1);
    end
  end

  // byte entering the shift register: message byte or pad byte
  logic         byte_en;
  logic [7:0]   byte_in;
  logic [511:0] msg_next;
  always_comb begin
    byte_en = 1'b0;
    byte_in = cmd_i.data;
    if (state_q == S_IDLE) begin
      byte_en = cmd_valid_i && !cmd_i.fin;
    end else if (state_q == S_PAD) begin
      byte_en = 1'b1;
      if (pad80_q) begin
        byte_in = 8'h80;
      end else if (fill_q >= 6'd56 && !ovf_q) begin
        byte_in = bitlen_q[{~fill_q[2:0], 3'b000} +: 8];
      end else begin
        byte_in = 8'h00;
      end
    end
  end
  assign msg_next = {msg_q[503:0], byte_in};

  // one sha-256 round plus message schedule step
  logic [31:0] wt, s0, s1, wnew, t1, t2, ea, aa;
  always_comb begin
    wt = w_q[0];
    s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    ea = v_q[4];
    aa = v_q[0];
    t1 = v_q[7] + (ror32(ea, 6) ^ ror32(ea, 11) ^ ror32(ea, 25))
       + ((ea & v_q[5]) ^ (~ea & v_q[6])) + round_k(rnd_q) + wt;
    t2 = (ror32(aa, 2) ^ ror32(aa, 13) ^ ror32(aa, 22))
       + ((aa & v_q[1]) ^ (aa & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign cmd_ready_o       = (state_q == S_IDLE);
  assign out_o.valid       = ovalid_q;
  assign out_o.word_index  = idx_q;
  assign out_o.digest_word = {h_q[{idx_q, 1'b0}], h_q[{idx_q, 1'b1}]};
  assign out_o.sum_result  = sum_q;
  assign out_o.crc_result  = crc_q;
  assign out_o.last        = (idx_q == 2'd3);

  // block shift register and schedule window
  always_ff @(posedge clk_i) begin
    if (byte_en) begin
      msg_q <= msg_next;
      if (fill_q == 6'd63) begin
        for (int i = 0; i < 16; i++) w_q[i] <= msg_next[511-32*i -: 32];
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end else if (state_q == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // control, counters and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      bitlen_q <= '0;
      sum_q    <= '0;
      crc_q    <= CrcInit;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      rnd_q    <= '0;
      final_q  <= 1'b0;
      second_q <= 1'b0;
      pad80_q  <= 1'b0;
      ovf_q    <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.fin) begin
              state_q  <= S_PAD;
              final_q  <= 1'b1;
              pad80_q  <= 1'b1;
              ovf_q    <= (fill_q >= 6'd56);
              second_q <= (fill_q >= 6'd56);
            end else begin
              sum_q    <= sum_q + {8'h00, cmd_i.data};
              crc_q    <= crc_next;
              bitlen_q <= bitlen_q + 64'd8;
              fill_q   <= fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                state_q <= S_ROUND;
                rnd_q   <= '0;
                final_q <= 1'b0;
              end
            end
          end
        end
        S_PAD: begin
          pad80_q <= 1'b0;
          fill_q  <= fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            state_q <= S_ROUND;
            rnd_q   <= '0;
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (!final_q) begin
            state_q <= S_IDLE;
          end else if (second_q) begin
            second_q <= 1'b0;
            ovf_q    <= 1'b0;
            state_q  <= S_PAD;
          end else begin
            state_q  <= S_EMIT;
            idx_q    <= '0;
            ovalid_q <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_o.ready) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              ovalid_q <= 1'b0;
              state_q  <= S_IDLE;
              fill_q   <= '0;
              bitlen_q <= '0;
              sum_q    <= '0;
              crc_q    <= CrcInit;
              final_q  <= 1'b0;
              ovf_q    <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ice_checker.sv
`default_nettype none
module ice_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_idx,
  input wire logic        out_last,
  input wire logic [15:0] out_sum
);

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_idx == 2'd3))) else $error("last mismatch");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid && out_idx == $past(out_idx) + 2'd1)
    else $error("result items out of order");

  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> $stable(out_sum)) else $error("sum changed");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");

endmodule

bind image_checksum_engine ice_checker u_checker (
  .clk_i, .rst_ni,
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_idx(out_o.word_index),
  .out_last(out_o.last), .out_sum(out_o.sum_result)
);
`default_nettype wire
